// ----- rtl/core/interleaved_trimmed_mean_assert.svh -----
// Assertion macros for the interleaved trimmed mean block.
// Each macro expects signals named clk and rst in the scope of use.
`ifndef INTERLEAVED_TRIMMED_MEAN_ASSERT_SVH
`define INTERLEAVED_TRIMMED_MEAN_ASSERT_SVH

// Same-cycle implication.
`define ITM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("itm assertion failed");

// Next-cycle implication.
`define ITM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("itm assertion failed");

`endif

// ----- rtl/core/itm_pkg.sv -----
`timescale 1ns / 1ps
package itm_pkg;

  // Burst limit; samples past it are ignored.
  localparam int MAX_SAMPLES = 256;

  localparam int SAMPLE_W = 16;
  localparam int VALUE_W  = 15;
  localparam int SEL_W    = 3;
  localparam int CHCNT_W  = 4;
  localparam int CFG_W    = 4;
  localparam int STATUS_W = 2;
  localparam int MAX_FRAME = 8;

  // Burst length and kept count hold values up to MAX_SAMPLES.
  localparam int BURST_W = $clog2(MAX_SAMPLES + 1);
  // Sum of up to MAX_SAMPLES clamped samples.
  localparam int SUM_W   = $clog2(MAX_SAMPLES * 32767 + 1);
  // Divisor is kept count minus two, at most MAX_SAMPLES - 2.
  localparam int DIV_W   = $clog2(MAX_SAMPLES - 1);
  // One quotient bit per divider step.
  localparam int DIV_STEPS = SUM_W;
  localparam int STEP_W  = $clog2(DIV_STEPS);

  localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

  // Configuration register indexes.
  localparam logic REG_SEL_CHANNEL   = 1'b0;
  localparam logic REG_CHANNEL_COUNT = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SHORT_BURST = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FEW_KEPT    = 2'd2;

  // Finished burst handed from front to back.
  typedef struct packed {
    logic [SUM_W-1:0]    sum;
    logic [VALUE_W-1:0]  min_v;
    logic [VALUE_W-1:0]  max_v;
    logic [BURST_W-1:0]  kept;
    logic [STATUS_W-1:0] status;
  } job_t;

endpackage

// ----- rtl/core/itm_if.sv -----
`timescale 1ns / 1ps
// Sample channel: one converter sample per word.
interface itm_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

// Result channel: one trimmed mean per burst.
interface itm_out_if;
  logic        valid;
  logic        ready;
  logic [14:0] average;
  logic [1:0]  status;

  modport source (output valid, output average, output status, input ready);
  modport sink   (input valid, input average, input status, output ready);
endinterface

// ----- rtl/core/interleaved_trimmed_mean.sv -----
`timescale 1ns / 1ps
// Channel    Dir  Payload                    Word
// samples    in   sample[15:0] s, last       one converter sample
// results    out  average[14:0], status[1:0] one trimmed mean per burst
// cfg_*      in   cfg_index, cfg_data[3:0]   register write, no handshake
//
// Samples are taken one per cycle while the queue is not full; each word of the
// selected channel updates sum, min, max and count. A burst ends in a result once
// the back end is free (load, 23 divider steps, output); errors skip the divider.
// Two finished bursts can wait in the queue; samples stall only when it is full.
// Reset (synchronous, active high) clears burst state, registers and queue
// at once; there is no clearing pass.
module interleaved_trimmed_mean import itm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  itm_in_if.sink           samples,
  itm_out_if.source        results
);

  logic q_full;
  logic q_push;
  job_t q_in;
  logic q_pop;
  logic q_not_empty;
  job_t q_out;

  itm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (samples),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  itm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_out)
  );

  itm_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_data      (q_out),
    .q_pop       (q_pop),
    .results     (results)
  );

endmodule

// ----- rtl/core/itm_front.sv -----
`timescale 1ns / 1ps
module itm_front import itm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  itm_in_if.sink              samples,
  input  logic                q_full,
  output logic                q_push,
  output job_t                q_data
);

  logic [SEL_W-1:0]   sel_channel;
  logic [CHCNT_W-1:0] channel_count;
  logic [SEL_W-1:0]   slot_pos;
  logic [BURST_W-1:0] burst_len;
  logic [BURST_W-1:0] kept_count;
  logic [SUM_W-1:0]   running_sum;
  logic [VALUE_W-1:0] min_seen;
  logic [VALUE_W-1:0] max_seen;

  logic [SEL_W-1:0]   slot_pos_next;
  logic [BURST_W-1:0] burst_len_next;
  logic [BURST_W-1:0] kept_count_next;
  logic [SUM_W-1:0]   running_sum_next;
  logic [VALUE_W-1:0] min_seen_next;
  logic [VALUE_W-1:0] max_seen_next;

  logic [CHCNT_W-1:0] flen;
  logic               in_room;
  logic               keep;
  logic [VALUE_W-1:0] clamped;
  logic [SEL_W:0]     slot_step;
  logic               take;

  assign samples.ready = !q_full;
  assign take = samples.valid && samples.ready;

  // Frame length, forced into 1..8.
  always_comb begin
    if (channel_count == '0) begin
      flen = CHCNT_W'(1);
    end else if (channel_count > CHCNT_W'(MAX_FRAME)) begin
      flen = CHCNT_W'(MAX_FRAME);
    end else begin
      flen = channel_count;
    end
  end

  // Running statistics for the current word.
  always_comb begin
    in_room   = burst_len < BURST_W'(MAX_SAMPLES);
    keep      = in_room && (slot_pos == sel_channel);
    clamped   = samples.sample[SAMPLE_W-1] ? '0 : samples.sample[VALUE_W-1:0];
    slot_step = {1'b0, slot_pos} + (SEL_W+1)'(1);

    running_sum_next = running_sum;
    kept_count_next  = kept_count;
    min_seen_next    = min_seen;
    max_seen_next    = max_seen;
    burst_len_next   = burst_len;
    slot_pos_next    = slot_pos;
    if (keep) begin
      running_sum_next = running_sum + SUM_W'(clamped);
      kept_count_next  = kept_count + BURST_W'(1);
      if (clamped < min_seen) min_seen_next = clamped;
      if (clamped > max_seen) max_seen_next = clamped;
    end
    if (in_room) begin
      burst_len_next = burst_len + BURST_W'(1);
      slot_pos_next  = (CHCNT_W'(slot_step) >= flen) ? '0 : slot_step[SEL_W-1:0];
    end
  end

  // Job for the back end, pushed on the last word.
  always_comb begin
    q_push       = take && samples.last;
    q_data.sum   = running_sum_next;
    q_data.min_v = min_seen_next;
    q_data.max_v = max_seen_next;
    q_data.kept  = kept_count_next;
    if (burst_len_next <= BURST_W'(flen)) begin
      q_data.status = ST_SHORT_BURST;
    end else if (kept_count_next < BURST_W'(3)) begin
      q_data.status = ST_FEW_KEPT;
    end else begin
      q_data.status = ST_OK;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sel_channel   <= '0;
      channel_count <= CHCNT_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SEL_CHANNEL:   sel_channel   <= cfg_data[SEL_W-1:0];
        REG_CHANNEL_COUNT: channel_count <= cfg_data[CHCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Burst state; cleared on reset and after the last word.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_pos    <= '0;
      burst_len   <= '0;
      kept_count  <= '0;
      running_sum <= '0;
      min_seen    <= VALUE_MAX;
      max_seen    <= '0;
    end else if (take) begin
      if (samples.last) begin
        slot_pos    <= '0;
        burst_len   <= '0;
        kept_count  <= '0;
        running_sum <= '0;
        min_seen    <= VALUE_MAX;
        max_seen    <= '0;
      end else begin
        slot_pos    <= slot_pos_next;
        burst_len   <= burst_len_next;
        kept_count  <= kept_count_next;
        running_sum <= running_sum_next;
        min_seen    <= min_seen_next;
        max_seen    <= max_seen_next;
      end
    end
  end

endmodule

// ----- rtl/core/itm_queue.sv -----
`timescale 1ns / 1ps
module itm_queue import itm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_data,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output job_t pop_data
);

  // Two-entry queue of finished bursts.
  job_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full      = fill == 2'd2;
  assign not_empty = fill != 2'd0;
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ----- rtl/core/itm_back.sv -----
`timescale 1ns / 1ps
module itm_back import itm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic q_not_empty,
  input  job_t q_data,
  output logic q_pop,
  itm_out_if.source results
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_DIV  = 2'd1;
  localparam logic [1:0] B_DONE = 2'd2;

  logic [1:0]          state;
  logic [SUM_W-1:0]    quot;
  logic [DIV_W-1:0]    divisor;
  logic [DIV_W-1:0]    rem;
  logic [STEP_W-1:0]   step;
  logic [STATUS_W-1:0] stat;
  logic                out_valid;
  logic [VALUE_W-1:0]  out_average;
  logic [STATUS_W-1:0] out_status;

  logic [DIV_W:0]      rem_shift;
  logic                fits;
  logic [DIV_W:0]      rem_sub;
  logic                out_free;

  assign q_pop = (state == B_IDLE) && q_not_empty;
  assign out_free = !out_valid || results.ready;

  assign results.valid   = out_valid;
  assign results.average = out_average;
  assign results.status  = out_status;

  // One restoring step: bring down the next dividend bit.
  always_comb begin
    rem_shift = {rem, quot[SUM_W-1]};
    fits      = rem_shift >= {1'b0, divisor};
    rem_sub   = rem_shift - {1'b0, divisor};
  end

  // Sequencer: load, divide bit by bit (skipped on an error status), hand to output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      step  <= '0;
    end else begin
      case (state)
        B_IDLE: begin
          if (q_not_empty) begin
            step <= '0;
            state <= (q_data.status == ST_OK) ? B_DIV : B_DONE;
          end
        end
        B_DIV: begin
          step <= step + STEP_W'(1);
          if (step == STEP_W'(DIV_STEPS - 1)) state <= B_DONE;
        end
        B_DONE: begin
          if (out_free) state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // Divider datapath; quotient builds up in place of the dividend.
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (q_not_empty) begin
          stat    <= q_data.status;
          rem     <= '0;
          divisor <= DIV_W'(q_data.kept - BURST_W'(2));
          if (q_data.status == ST_OK) begin
            quot <= q_data.sum - SUM_W'(q_data.min_v) - SUM_W'(q_data.max_v);
          end else begin
            quot <= '0;
          end
        end
      end
      B_DIV: begin
        rem  <= fits ? rem_sub[DIV_W-1:0] : rem_shift[DIV_W-1:0];
        quot <= {quot[SUM_W-2:0], fits};
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == B_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_DONE && out_free) begin
      out_average <= quot[VALUE_W-1:0];
      out_status  <= stat;
    end
  end

endmodule

// ----- rtl/core/itm_checker.sv -----
`timescale 1ns / 1ps
`include "interleaved_trimmed_mean_assert.svh"
module itm_checker import itm_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                in_last,
  input logic                out_valid,
  input logic                out_ready,
  input logic [VALUE_W-1:0]  out_average,
  input logic [STATUS_W-1:0] out_status
);

  // A held result word keeps valid and payload.
  `ITM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `ITM_ASSERT_NEXT(a_out_stable, out_valid && !out_ready,
                   $stable(out_average) && $stable(out_status))
  // Error results carry a zero average.
  `ITM_ASSERT_NOW(a_err_zero, out_valid && out_status != ST_OK, out_average == '0)
  // A waiting sample word stays offered with the same last flag.
  `ITM_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_last))

endmodule

bind interleaved_trimmed_mean itm_checker u_itm_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (samples.valid),
  .in_ready    (samples.ready),
  .in_last     (samples.last),
  .out_valid   (results.valid),
  .out_ready   (results.ready),
  .out_average (results.average),
  .out_status  (results.status)
);
